// File: sv/sdba_pkg.sv
`timescale 1ns / 1ps
package sdba_pkg;

  localparam int N   = 32;
  // input edge to result strobe: unpack, combine, pack, output register
  localparam int LAT = 2 * N + 2;

  typedef logic [N-1:0] word_t;
  typedef logic signed [1:0] dig_t;
  typedef dig_t [N-1:0] dvec_t;
  typedef logic [2:0] cmd_t;

  localparam cmd_t CMD_TO_T   = 3'd0;
  localparam cmd_t CMD_FROM_T = 3'd1;
  localparam cmd_t CMD_ADD    = 3'd2;
  localparam cmd_t CMD_SUB    = 3'd3;
  localparam cmd_t CMD_DIV    = 3'd4;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } ctl_t;

  // One bit position of one correction step: x is the bit, e the pending
  // weighted previous bit, c the signed carry.
  typedef struct packed {
    logic x;
    dig_t e;
    dig_t c;
  } cell_t;

  // Forward step: r + 2(r & P) - 2(r & M), one bit at a time.
  function automatic cell_t fwd_cell(logic x, dig_t e, dig_t c, logic pb, logic mb);
    logic [2:0] v;
    cell_t      o;
    v   = {2'b00, x} + {e[1], e} + {c[1], c};
    o.x = v[0];
    o.c = v[2:1];
    o.e = (x & pb) ? 2'sd1 : ((x & mb) ? -2'sd1 : 2'sd0);
    return o;
  endfunction

  // Inverse step: recover the input bit from the output bit, then advance.
  function automatic cell_t inv_cell(logic y, dig_t e, dig_t c, logic pb, logic mb);
    logic  x;
    cell_t o;
    x   = y ^ e[0] ^ c[0];
    o   = fwd_cell(x, e, c, pb, mb);
    o.x = x;
    return o;
  endfunction

endpackage

// File: sv/signed_digit_base_arith.sv
`timescale 1ns / 1ps
// T-base arithmetic unit, masks set through the cfg_ write port
// (index 0 minus mask, index 1 plus mask). Write them only while no word
// is in flight.
// Issue a word by raising start with in_cmd and both operands; it is taken
// at any clock edge where start is high and busy is low. busy is low
// whenever rst_n is high, so one word can be issued every cycle.
// Each word gives one result: out_valid rises together with out_result.
// Throughput is one word per cycle. The pipeline is made of two 32-stage
// bit-serial pipelines: one stage per bit position, each stage running
// that bit through all 32 correction steps. The first pipeline brings both
// operands out of T form, one register stage combines them, the second
// pipeline brings the value back to T form and peels quotient bits for
// the divide, and one output register drives the result ports.
// The result side has no back-pressure; results are never held.
// Reset clears both masks and drops every word in flight.
module signed_digit_base_arith import sdba_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_cmd,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  output logic [31:0] out_result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam logic CFG_MINUS = 1'b0;
  localparam logic CFG_PLUS  = 1'b1;

  word_t minus_mask_r, plus_mask_r;
  word_t p_mask, m_mask;

  ctl_t  in_ctl;
  ctl_t  up_ctl;
  word_t up_a, up_abin, up_bbin;
  logic  up_active;

  ctl_t  cb_ctl_r;
  word_t cb_r_r, cb_d_r;
  word_t cb_r_nxt;

  ctl_t  pk_ctl;
  word_t pk_r, pk_res;
  logic  pk_active;

  logic  out_valid_r;
  word_t out_result_r, out_result_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minus_mask_r <= '0;
      plus_mask_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MINUS: minus_mask_r <= cfg_wdata;
        CFG_PLUS:  plus_mask_r  <= cfg_wdata;
      endcase
    end
  end

  // positions marked in both masks cancel
  assign p_mask = plus_mask_r & ~minus_mask_r;
  assign m_mask = minus_mask_r & ~plus_mask_r;

  assign busy       = ~rst_n;
  assign in_ctl.valid = start & ~busy;
  assign in_ctl.cmd   = in_cmd;

  sdba_unpack u_unpack (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ctl   (in_ctl),
    .in_a     (in_operand_a),
    .in_b     (in_operand_b),
    .p_mask   (p_mask),
    .m_mask   (m_mask),
    .out_ctl  (up_ctl),
    .out_a    (up_a),
    .out_abin (up_abin),
    .out_bbin (up_bbin),
    .active   (up_active)
  );

  always_comb begin
    unique case (up_ctl.cmd)
      CMD_TO_T:   cb_r_nxt = up_a;
      CMD_FROM_T: cb_r_nxt = up_abin;
      CMD_ADD:    cb_r_nxt = up_abin + up_bbin;
      CMD_SUB:    cb_r_nxt = up_abin - up_bbin;
      CMD_DIV:    cb_r_nxt = up_abin;
      default:    cb_r_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cb_ctl_r <= '0;
    end else begin
      cb_ctl_r <= up_ctl;
    end
  end

  always_ff @(posedge clk) begin
    cb_r_r <= cb_r_nxt;
    cb_d_r <= up_bbin;
  end

  sdba_pack u_pack (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ctl  (cb_ctl_r),
    .in_r    (cb_r_r),
    .in_d    (cb_d_r),
    .p_mask  (p_mask),
    .m_mask  (m_mask),
    .out_ctl (pk_ctl),
    .out_r   (pk_r),
    .out_res (pk_res),
    .active  (pk_active)
  );

  always_comb begin
    unique case (pk_ctl.cmd)
      CMD_TO_T, CMD_ADD, CMD_SUB, CMD_DIV: out_result_nxt = pk_res;
      CMD_FROM_T:                          out_result_nxt = pk_r;
      default:                             out_result_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= pk_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result strobe without a word issued at the pipeline depth");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !(up_active || pk_active || cb_ctl_r.valid || out_valid_r))
    else $error("mask write while words are in flight");

endmodule

// File: sv/sdba_unpack.sv
`timescale 1ns / 1ps
module sdba_unpack import sdba_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  ctl_t  in_ctl,
  input  word_t in_a,
  input  word_t in_b,
  input  word_t p_mask,
  input  word_t m_mask,
  output ctl_t  out_ctl,
  output word_t out_a,
  output word_t out_abin,
  output word_t out_bbin,
  output logic  active
);

  ctl_t  ctl_r [N];
  word_t a_r   [N];
  word_t b_r   [N];
  word_t ab_r  [N];
  word_t bb_r  [N];
  dvec_t ea_r  [N];
  dvec_t ca_r  [N];
  dvec_t eb_r  [N];
  dvec_t cb_r  [N];

  genvar k;
  for (k = 0; k < N; k++) begin : g_stage
    ctl_t  s_ctl;
    word_t s_a, s_b, s_ab, s_bb;
    dvec_t s_ea, s_ca, s_eb, s_cb;
    dvec_t ea_nxt, ca_nxt, eb_nxt, cb_nxt;
    word_t ab_nxt, bb_nxt;
    word_t psh, msh;
    logic  xa, xb;
    cell_t ra, rb;

    if (k == 0) begin : g_src
      assign s_ctl = in_ctl;
      assign s_a   = in_a;
      assign s_b   = in_b;
      assign s_ab  = '0;
      assign s_bb  = '0;
      assign s_ea  = '0;
      assign s_ca  = '0;
      assign s_eb  = '0;
      assign s_cb  = '0;
    end else begin : g_src
      assign s_ctl = ctl_r[k-1];
      assign s_a   = a_r[k-1];
      assign s_b   = b_r[k-1];
      assign s_ab  = ab_r[k-1];
      assign s_bb  = bb_r[k-1];
      assign s_ea  = ea_r[k-1];
      assign s_ca  = ca_r[k-1];
      assign s_eb  = eb_r[k-1];
      assign s_cb  = cb_r[k-1];
    end

    // bit k through the inverse steps, last correction step first
    always_comb begin
      xa     = s_a[k];
      xb     = s_b[k];
      ea_nxt = s_ea;
      ca_nxt = s_ca;
      eb_nxt = s_eb;
      cb_nxt = s_cb;
      psh    = '0;
      msh    = '0;
      ra     = '0;
      rb     = '0;
      for (int j = N - 1; j >= 0; j--) begin
        psh       = p_mask << j;
        msh       = m_mask << j;
        ra        = inv_cell(xa, s_ea[j], s_ca[j], psh[k], msh[k]);
        rb        = inv_cell(xb, s_eb[j], s_cb[j], psh[k], msh[k]);
        ea_nxt[j] = ra.e;
        ca_nxt[j] = ra.c;
        eb_nxt[j] = rb.e;
        cb_nxt[j] = rb.c;
        xa        = ra.x;
        xb        = rb.x;
      end
      ab_nxt    = s_ab;
      bb_nxt    = s_bb;
      ab_nxt[k] = xa;
      bb_nxt[k] = xb;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else begin
        ctl_r[k] <= s_ctl;
      end
    end

    always_ff @(posedge clk) begin
      a_r[k]  <= s_a;
      b_r[k]  <= s_b;
      ab_r[k] <= ab_nxt;
      bb_r[k] <= bb_nxt;
      ea_r[k] <= ea_nxt;
      ca_r[k] <= ca_nxt;
      eb_r[k] <= eb_nxt;
      cb_r[k] <= cb_nxt;
    end
  end

  always_comb begin
    active = 1'b0;
    for (int i = 0; i < N; i++) begin
      active = active | ctl_r[i].valid;
    end
  end

  assign out_ctl  = ctl_r[N-1];
  assign out_a    = a_r[N-1];
  assign out_abin = ab_r[N-1];
  assign out_bbin = bb_r[N-1];

endmodule

// File: sv/sdba_pack.sv
`timescale 1ns / 1ps
module sdba_pack import sdba_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  ctl_t  in_ctl,
  input  word_t in_r,
  input  word_t in_d,
  input  word_t p_mask,
  input  word_t m_mask,
  output ctl_t  out_ctl,
  output word_t out_r,
  output word_t out_res,
  output logic  active
);

  ctl_t  ctl_r [N];
  word_t r_r   [N];
  word_t d_r   [N];
  word_t res_r [N];
  dvec_t e_r   [N];
  dvec_t c_r   [N];

  genvar k;
  for (k = 0; k < N; k++) begin : g_stage
    ctl_t  s_ctl;
    word_t s_r, s_d, s_res;
    dvec_t s_e, s_c;
    dvec_t e_nxt, c_nxt;
    word_t r_nxt, res_nxt;
    word_t psh, msh;
    logic  x1, x2, t;
    cell_t c1, c2;

    if (k == 0) begin : g_src
      assign s_ctl = in_ctl;
      assign s_r   = in_r;
      assign s_d   = in_d;
      assign s_res = '0;
      assign s_e   = '0;
      assign s_c   = '0;
    end else begin : g_src
      assign s_ctl = ctl_r[k-1];
      assign s_r   = r_r[k-1];
      assign s_d   = d_r[k-1];
      assign s_res = res_r[k-1];
      assign s_e   = e_r[k-1];
      assign s_c   = c_r[k-1];
    end

    always_comb begin
      // tentative bit k of the T form
      x1  = s_r[k];
      psh = '0;
      msh = '0;
      c1  = '0;
      for (int j = 0; j < N; j++) begin
        psh = p_mask << j;
        msh = m_mask << j;
        c1  = fwd_cell(x1, s_e[j], s_c[j], psh[k], msh[k]);
        x1  = c1.x;
      end
      t = x1;
      // on a quotient bit, take the divisor off at weight 2^k
      if (s_ctl.cmd == CMD_DIV && t) begin
        r_nxt = s_r - word_t'(s_d << k);
      end else begin
        r_nxt = s_r;
      end
      // advance the step states with the settled bit
      x2    = r_nxt[k];
      e_nxt = s_e;
      c_nxt = s_c;
      c2    = '0;
      for (int j = 0; j < N; j++) begin
        psh      = p_mask << j;
        msh      = m_mask << j;
        c2       = fwd_cell(x2, s_e[j], s_c[j], psh[k], msh[k]);
        e_nxt[j] = c2.e;
        c_nxt[j] = c2.c;
        x2       = c2.x;
      end
      res_nxt    = s_res;
      res_nxt[k] = t;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k] <= '0;
      end else begin
        ctl_r[k] <= s_ctl;
      end
    end

    always_ff @(posedge clk) begin
      r_r[k]   <= r_nxt;
      d_r[k]   <= s_d;
      res_r[k] <= res_nxt;
      e_r[k]   <= e_nxt;
      c_r[k]   <= c_nxt;
    end
  end

  always_comb begin
    active = 1'b0;
    for (int i = 0; i < N; i++) begin
      active = active | ctl_r[i].valid;
    end
  end

  assign out_ctl = ctl_r[N-1];
  assign out_r   = r_r[N-1];
  assign out_res = res_r[N-1];

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import sdba_pkg::*;

  localparam logic IDX_MINUS = 1'b0;
  localparam logic IDX_PLUS  = 1'b1;
  localparam int   IDLE_LIMIT = 5000;
  localparam int   RAND_PHASES = 8;
  localparam int   WORDS_PER_PHASE = 228;

  typedef struct {
    cmd_t        cmd;
    logic [31:0] a;
    logic [31:0] b;
    bit          typed;
    logic [31:0] want;
  } vec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_cmd = '0;
  logic [31:0] in_operand_a = '0;
  logic [31:0] in_operand_b = '0;
  logic        out_valid;
  logic [31:0] out_result;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;

  logic [31:0] minus_m = '0;
  logic [31:0] plus_m = '0;
  logic [31:0] pending_q[$];
  bit          typed_now = 0;
  logic [31:0] typed_val = '0;
  bit          took = 0;
  int          errors = 0;
  int          idle_cycles = 0;
  int          cmd_seen[8];
  int          results_seen = 0;
  vec_t        dir_tab[$];

  always #5 clk = ~clk;

  signed_digit_base_arith u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_operand_a(in_operand_a), .in_operand_b(in_operand_b),
    .out_valid(out_valid), .out_result(out_result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  function automatic logic [31:0] tbase_encode(logic [31:0] tm, logic [31:0] tp,
                                               logic [31:0] r);
    for (int i = 0; i < 32; i++) begin
      r = r - ((r & tm) << 1) + ((r & tp) << 1);
      tm = tm << 1;
      tp = tp << 1;
    end
    return r;
  endfunction

  function automatic logic [31:0] tbase_decode(logic [31:0] tm, logic [31:0] tp,
                                               logic [31:0] r);
    logic [31:0] um, up, bitm, stepv;
    for (int x = 31; x >= 0; x--) begin
      um = tm << x;
      up = tp << x;
      for (int y = x; y < 32; y++) begin
        bitm  = 32'd1 << y;
        stepv = (y == 31) ? 32'd0 : (32'd1 << (y + 1));
        if ((r & um & bitm) != 0) r = r + stepv;
        if ((r & up & bitm) != 0) r = r - stepv;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] tbase_sum(logic [31:0] tm, logic [31:0] tp,
                                            logic [31:0] a, logic [31:0] b, bit neg);
    logic [31:0] da, db;
    da = tbase_decode(tm, tp, a);
    db = tbase_decode(tm, tp, b);
    return tbase_encode(tm, tp, neg ? da - db : da + db);
  endfunction

  function automatic logic [31:0] tbase_odd_div(logic [31:0] tm, logic [31:0] tp,
                                                logic [31:0] rem, logic [31:0] dv);
    logic [31:0] q;
    q = '0;
    for (int i = 0; i < 32; i++) begin
      if (rem[i]) begin
        rem = tbase_sum(tm, tp, rem, dv, 1'b1);
        q[i] = 1'b1;
      end
      dv = tbase_sum(tm, tp, dv, dv, 1'b0);
    end
    return q;
  endfunction

  function automatic logic [31:0] tbase_result(cmd_t c, logic [31:0] a, logic [31:0] b);
    case (c)
      CMD_TO_T:   return tbase_encode(minus_m, plus_m, a);
      CMD_FROM_T: return tbase_decode(minus_m, plus_m, a);
      CMD_ADD:    return tbase_sum(minus_m, plus_m, a, b, 1'b0);
      CMD_SUB:    return tbase_sum(minus_m, plus_m, a, b, 1'b1);
      CMD_DIV:    return tbase_odd_div(minus_m, plus_m, a, b);
      default:    return 32'd0;
    endcase
  endfunction

  // predict on every taken word, check every strobed result
  always @(posedge clk) begin
    logic [31:0] want;
    took = rst_n && start && !busy;
    if (took) begin
      pending_q.push_back(typed_now ? typed_val : tbase_result(in_cmd, in_operand_a,
                                                               in_operand_b));
      cmd_seen[in_cmd]++;
    end
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t: result %h with nothing pending", $time, out_result);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (out_result !== want) begin
          $display("%0t: result mismatch expected %h actual %h", $time, want, out_result);
          errors++;
        end
      end
    end
    if (took || (rst_n && out_valid)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: watchdog expired, %0d results pending", $time, pending_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic drain();
    while (pending_q.size() > 0) @(negedge clk);
    repeat (LAT + 4) @(negedge clk);
  endtask

  task automatic write_mask(logic idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == IDX_MINUS) minus_m = v;
    else plus_m = v;
  endtask

  task automatic set_masks(logic [31:0] m, logic [31:0] p);
    drain();
    write_mask(IDX_MINUS, m);
    write_mask(IDX_PLUS, p);
  endtask

  // hold the word until taken, then idle a random gap
  task automatic send_word(cmd_t c, logic [31:0] a, logic [31:0] b, bit typed,
                           logic [31:0] want);
    int r, gap;
    in_cmd <= c;
    in_operand_a <= a;
    in_operand_b <= b;
    typed_now = typed;
    typed_val = want;
    start <= 1'b1;
    do @(negedge clk); while (!took);
    r = $urandom_range(0, 99);
    gap = (r < 55) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'd1 << $urandom_range(0, 31);
      3: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom & $urandom;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    cmd_t c;
    int r;
    dir_tab = '{
      '{CMD_TO_T,   32'h0000_0000, 32'h0,          1, 32'h0000_0000},
      '{CMD_TO_T,   32'hFFFF_FFFF, 32'h0,          1, 32'hFFFF_FFFF},
      '{CMD_FROM_T, 32'h8000_0000, 32'hFFFF_FFFF,  1, 32'h8000_0000},
      '{CMD_FROM_T, 32'h0000_0001, 32'h0,          1, 32'h0000_0001},
      '{CMD_ADD,    32'hFFFF_FFFF, 32'h0000_0001,  1, 32'h0000_0000},
      '{CMD_ADD,    32'h8000_0000, 32'h8000_0000,  1, 32'h0000_0000},
      '{CMD_SUB,    32'h0000_0000, 32'h0000_0001,  1, 32'hFFFF_FFFF},
      '{CMD_SUB,    32'hFFFF_FFFF, 32'hFFFF_FFFF,  1, 32'h0000_0000},
      '{CMD_DIV,    32'hFFFF_FFFF, 32'h0000_0001,  1, 32'hFFFF_FFFF},
      '{CMD_DIV,    32'h0000_0000, 32'h0000_0003,  1, 32'h0000_0000},
      '{CMD_DIV,    32'h1234_5679, 32'hFFFF_FFFF,  0, 32'h0},
      '{CMD_DIV,    32'hFFFF_FFFF, 32'h8000_0001,  0, 32'h0},
      '{cmd_t'(5),  32'hFFFF_FFFF, 32'hFFFF_FFFF,  1, 32'h0000_0000},
      '{cmd_t'(6),  32'h1234_5678, 32'h0,          1, 32'h0000_0000},
      '{cmd_t'(7),  32'h0000_0001, 32'h1,          1, 32'h0000_0000}
    };
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset masks, then the same rows at the mask extremes
    foreach (dir_tab[i])
      send_word(dir_tab[i].cmd, dir_tab[i].a, dir_tab[i].b, dir_tab[i].typed, dir_tab[i].want);
    start <= 1'b0;
    set_masks(32'hFFFF_FFFF, 32'h0);
    foreach (dir_tab[i]) send_word(dir_tab[i].cmd, dir_tab[i].a, dir_tab[i].b, 0, 0);
    start <= 1'b0;
    set_masks(32'h0, 32'hFFFF_FFFF);
    foreach (dir_tab[i]) send_word(dir_tab[i].cmd, dir_tab[i].a, dir_tab[i].b, 0, 0);
    start <= 1'b0;

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: set_masks(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        1: set_masks(32'h0, 32'h0);
        default: set_masks(pick_mask(), pick_mask());
      endcase
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        r = $urandom_range(0, 99);
        c = (r < 4) ? cmd_t'($urandom_range(5, 7)) : cmd_t'(r % 5);
        send_word(c, pick_operand(), pick_operand(), 0, 0);
      end
      start <= 1'b0;
    end

    drain();
    $display("Covered %0d results over %0d mask settings: to_t %0d from_t %0d add %0d",
             results_seen, RAND_PHASES + 3, cmd_seen[0], cmd_seen[1], cmd_seen[2]);
    $display("  sub %0d divide %0d unused codes %0d", cmd_seen[3], cmd_seen[4],
             cmd_seen[5] + cmd_seen[6] + cmd_seen[7]);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// File: filelist.f
sv/sdba_pkg.sv
sv/sdba_unpack.sv
sv/sdba_pack.sv
sv/signed_digit_base_arith.sv
sim/tb.sv
